[rtl/core/luxasc_pkg.sv]
// Shared types and constants for the lux reading to ASCII decimal converter.
// Depends on nothing; used by every module of the block.
package luxasc_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned PROD5_W   = 19;
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned DIGIT_CNT = 5;
  localparam int unsigned POS_W     = 3;

  // floor(x / 6) == (x * DIV6_RECIP) >> DIV6_SHIFT for every x below 2**19.
  localparam int unsigned DIV6_SHIFT = 21;
  localparam logic [PROD5_W-1:0] DIV6_RECIP = 19'd349526;

  localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'd48;
  localparam logic [BYTE_W-1:0] LINE_FEED  = 8'h0A;

  // Position code that selects the closing line feed.
  localparam logic [POS_W-1:0] LF_POS = POS_W'(DIGIT_CNT);

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef logic [0:DIGIT_CNT-1][DIGIT_W-1:0] digits_t;

  typedef struct packed {
    digits_t          digits;
    logic [POS_W-1:0] first;
  } item_t;

endpackage

[rtl/core/lux_reading_to_ascii_decimal.sv]
// Top level of the lux reading to ASCII decimal converter.
// Depends on luxasc_pkg, luxasc_front, luxasc_queue and luxasc_back.
//
// Each input beat carries the two raw sensor bytes, high byte first. The
// count they form is scaled to floor(count*5/6) and sent on the output
// channel as unsigned decimal ASCII, most significant digit first, with no
// leading zeros (zero gives a single '0'), then a line feed with
// out_is_last set. A reading yields two to six output beats.
// An accepted input beat passes through six pipeline stages in the front,
// one in the queue and one in the output register before its first output
// beat goes out. The output register sends one beat per cycle while
// out_ready is high; a reading of n digits takes n+1 output beats, and
// readings may be accepted back to back while earlier ones are being sent.
// A four-entry queue parts the digit pipeline from the byte emitter; when
// the receiver holds out_ready low the output beat holds, the queue fills,
// and then in_ready drops until space frees up.
// Reset (synchronous, active low) empties the pipeline, the queue and the
// output register; the block keeps no other state.
module lux_reading_to_ascii_decimal (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [luxasc_pkg::BYTE_W-1:0] in_raw_high,
  input  logic [luxasc_pkg::BYTE_W-1:0] in_raw_low,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [luxasc_pkg::BYTE_W-1:0] out_char,
  output logic                          out_is_last
);

  logic              q_push, q_ready, q_valid, q_pop;
  luxasc_pkg::item_t push_item, head_item;

  luxasc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_raw_high(in_raw_high),
    .in_raw_low (in_raw_low),
    .q_push     (q_push),
    .q_ready    (q_ready),
    .q_item     (push_item)
  );

  luxasc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_ready(q_ready),
    .push_item (push_item),
    .head_valid(q_valid),
    .pop       (q_pop),
    .head_item (head_item)
  );

  luxasc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (head_item),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_char   (out_char),
    .out_is_last(out_is_last)
  );

`ifndef SYNTHESIS
  // The closing beat of a reading is always a line feed.
  a_last_is_lf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_last |-> out_char == luxasc_pkg::LINE_FEED)
    else $error("last beat is not a line feed");

  // Every other beat is a decimal digit.
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_last |->
      out_char >= luxasc_pkg::ASCII_ZERO && out_char <= luxasc_pkg::ASCII_ZERO + 8'd9)
    else $error("non-last beat is not a decimal digit");

  // A digit beat is always followed at once by the rest of its reading.
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_is_last |=> out_valid)
    else $error("gap inside a reading");

  // Nothing is offered on the output right after reset.
  a_reset_idle: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("output valid right after reset");
`endif

endmodule

[rtl/core/luxasc_front.sv]
// Front pipeline: joins the raw bytes, scales by 5/6 and splits the value into
// decimal digits with the leading digit position. Uses luxasc_pkg.
module luxasc_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [luxasc_pkg::BYTE_W-1:0]       in_raw_high,
  input  logic [luxasc_pkg::BYTE_W-1:0]       in_raw_low,
  output logic                                q_push,
  input  logic                                q_ready,
  output luxasc_pkg::item_t                   q_item
);

  function automatic logic [19:0] dig_split(input logic [15:0] v, input logic [15:0] p);
    logic [17:0] m;
    logic [3:0]  d;
    logic [15:0] r;
    d = '0;
    r = v;
    for (int k = 1; k < 10; k++) begin
      m = 18'(k) * {2'b00, p};
      if ({2'b00, v} >= m) begin
        d = 4'(k);
        r = 16'({2'b00, v} - m);
      end
    end
    return {d, r};
  endfunction

  logic                                  adv;
  logic [luxasc_pkg::COUNT_W-1:0]        count;
  logic [2*luxasc_pkg::PROD5_W-1:0]      prod;
  logic [19:0]                           sp3, sp4, sp5, sp6;

  logic                                  v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic [luxasc_pkg::PROD5_W-1:0]        p5_r;
  logic [luxasc_pkg::COUNT_W-1:0]        val2_r;
  logic [13:0]                           rem3_r;
  logic [9:0]                            rem4_r;
  logic [6:0]                            rem5_r;
  luxasc_pkg::digits_t                   dig3_r, dig4_r, dig5_r, dig6_r;
  logic [luxasc_pkg::POS_W-1:0]          first;

  assign adv      = !v6_r || q_ready;
  assign in_ready = adv;
  assign q_push   = v6_r && q_ready;

  assign count = {in_raw_high, in_raw_low};
  assign prod  = (2*luxasc_pkg::PROD5_W)'(p5_r) *
                 (2*luxasc_pkg::PROD5_W)'(luxasc_pkg::DIV6_RECIP);

  assign sp3 = dig_split(val2_r, 16'd10000);
  assign sp4 = dig_split(16'(rem3_r), 16'd1000);
  assign sp5 = dig_split(16'(rem4_r), 16'd100);
  assign sp6 = dig_split(16'(rem5_r), 16'd10);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p5_r   <= ({3'b000, count} << 2) + {3'b000, count};
      val2_r <= prod[luxasc_pkg::DIV6_SHIFT +: luxasc_pkg::COUNT_W];

      dig3_r <= {sp3[19:16], 16'h0000};
      rem3_r <= sp3[13:0];

      dig4_r <= {dig3_r[0], sp4[19:16], 12'h000};
      rem4_r <= sp4[9:0];

      dig5_r <= {dig4_r[0], dig4_r[1], sp5[19:16], 8'h00};
      rem5_r <= sp5[6:0];

      dig6_r <= {dig5_r[0], dig5_r[1], dig5_r[2], sp6[19:16], sp6[3:0]};
    end
  end

  always_comb begin
    first = luxasc_pkg::POS_W'(luxasc_pkg::DIGIT_CNT - 1);
    for (int i = luxasc_pkg::DIGIT_CNT - 2; i >= 0; i--) begin
      if (dig6_r[i] != '0) begin
        first = luxasc_pkg::POS_W'(i);
      end
    end
  end

  assign q_item.digits = dig6_r;
  assign q_item.first  = first;

endmodule

[rtl/core/luxasc_queue.sv]
// Small register queue between the digit pipeline and the byte emitter.
// Uses luxasc_pkg for the item type and depth.
module luxasc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              push_ready,
  input  luxasc_pkg::item_t push_item,
  output logic              head_valid,
  input  logic              pop,
  output luxasc_pkg::item_t head_item
);

  luxasc_pkg::item_t                 mem_r [luxasc_pkg::QDEPTH];
  logic [luxasc_pkg::QPTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [luxasc_pkg::QCNT_W-1:0]     count_r;
  logic                              do_push, do_pop;

  assign push_ready = count_r != luxasc_pkg::QCNT_W'(luxasc_pkg::QDEPTH);
  assign head_valid = count_r != '0;
  assign head_item  = mem_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

[rtl/core/luxasc_back.sv]
// Byte emitter: walks the digits of the queue head and sends one ASCII beat
// per cycle, stalled by out_ready, via an output register. Uses luxasc_pkg.
module luxasc_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  luxasc_pkg::item_t             q_item,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [luxasc_pkg::BYTE_W-1:0] out_char,
  output logic                          out_is_last
);

  logic                                 out_valid_r;
  logic [luxasc_pkg::BYTE_W-1:0]        out_char_r;
  logic                                 out_is_last_r;
  logic                                 started_r;
  logic [luxasc_pkg::POS_W-1:0]         pos_r;

  logic                                 load;
  logic [luxasc_pkg::POS_W-1:0]         pos;
  logic                                 emit_lf;
  logic [luxasc_pkg::DIGIT_W-1:0]       digit;

  assign load    = !out_valid_r || out_ready;
  assign pos     = started_r ? pos_r : q_item.first;
  assign emit_lf = pos == luxasc_pkg::LF_POS;
  assign q_pop   = load && q_valid && emit_lf;

  always_comb begin
    digit = '0;
    if (!emit_lf) begin
      digit = q_item.digits[pos];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      started_r   <= 1'b0;
      pos_r       <= '0;
    end else if (load) begin
      out_valid_r <= q_valid;
      if (q_valid) begin
        started_r <= !emit_lf;
        pos_r     <= pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && q_valid) begin
      out_char_r    <= emit_lf ? luxasc_pkg::LINE_FEED
                               : luxasc_pkg::ASCII_ZERO + {4'b0000, digit};
      out_is_last_r <= emit_lf;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_char    = out_char_r;
  assign out_is_last = out_is_last_r;

endmodule
